// ===== sv/bcpc_pkg.sv =====
// ============================================================================
// bcpc_pkg - shared definitions for the button click / press classifier
// Register indexes, field widths and reset values used by all modules.
// ============================================================================
`default_nettype none

package bcpc_pkg;

    // Default number of buttons handled by the block.
    localparam int unsigned NUM_BUTTONS_DEF = 4;

    // Width of the hold counter and of both limit registers.
    localparam int unsigned CNT_W   = 14;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration port.
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLICK_LIMIT   = 1'b0,
        CFG_TIMEOUT_LIMIT = 1'b1
    } t_cfg_reg;

    localparam logic [CNT_W-1:0] CLICK_LIMIT_RST   = CNT_W'(8);
    localparam logic [CNT_W-1:0] TIMEOUT_LIMIT_RST = CNT_W'(10000);

    // Item kinds carried in the mode field.
    typedef enum logic {
        MODE_EDGE = 1'b0,
        MODE_TICK = 1'b1
    } t_mode;

endpackage : bcpc_pkg

`default_nettype wire

// ===== sv/bcpc_cfg.sv =====
// ============================================================================
// bcpc_cfg - configuration registers
// Holds the click and timeout limits, written through the configuration port.
// ============================================================================
`default_nettype none

module bcpc_cfg
    import bcpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CNT_W-1:0]     i_cfg_data,
    output logic [CNT_W-1:0]          o_click_limit,
    output logic [CNT_W-1:0]          o_timeout_limit
);

    logic [CNT_W-1:0] r_click_limit;
    logic [CNT_W-1:0] r_timeout_limit;

    // The registers take every write directly, so the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_limit   <= CLICK_LIMIT_RST;
            r_timeout_limit <= TIMEOUT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CLICK_LIMIT:   r_click_limit   <= i_cfg_data;
                CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_click_limit   = r_click_limit;
    assign o_timeout_limit = r_timeout_limit;

endmodule : bcpc_cfg

`default_nettype wire

// ===== sv/bcpc_track.sv =====
// ============================================================================
// bcpc_track - tracking state and per-item update
// Holds the tracked button, hold counter and press flags, and computes the
// result of one item from the current state in a single step.
// ============================================================================
`default_nettype none

module bcpc_track
    import bcpc_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int unsigned BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_mode,
    input  wire logic [BTN_W-1:0]       i_button_index,
    input  wire logic [NUM_BUTTONS-1:0] i_pin_levels,
    input  wire logic [CNT_W-1:0]       i_click_limit,
    input  wire logic [CNT_W-1:0]       i_timeout_limit,
    output logic                        o_click_valid,
    output logic [BTN_W-1:0]            o_click_button,
    output logic [NUM_BUTTONS-1:0]      o_press_mask,
    output logic                        o_busy_res
);

    logic                   r_tracking;
    logic [BTN_W-1:0]       r_tracked_button;
    logic [CNT_W-1:0]       r_hold_count;
    logic [NUM_BUTTONS-1:0] r_press_flags;

    logic                   n_tracking;
    logic [BTN_W-1:0]       n_tracked_button;
    logic [CNT_W-1:0]       n_hold_count;
    logic [NUM_BUTTONS-1:0] n_press_flags;

    logic                   pin_low;
    logic                   index_ok;
    logic [CNT_W-1:0]       count_inc;
    logic [NUM_BUTTONS-1:0] button_bit;
    logic                   click;

    assign pin_low    = ~i_pin_levels[r_tracked_button];
    assign index_ok   = ({1'b0, i_button_index} < (BTN_W+1)'(NUM_BUTTONS));
    assign count_inc  = (r_hold_count < CNT_MAX) ? (r_hold_count + CNT_W'(1)) : r_hold_count;
    assign button_bit = NUM_BUTTONS'(1) << r_tracked_button;

    always_comb begin
        n_tracking       = r_tracking;
        n_tracked_button = r_tracked_button;
        n_hold_count     = r_hold_count;
        n_press_flags    = r_press_flags;
        click            = 1'b0;

        if (t_mode'(i_mode) == MODE_EDGE) begin
            // Edges only matter while idle; they lock onto one button.
            if (!r_tracking && index_ok) begin
                n_tracking       = 1'b1;
                n_tracked_button = i_button_index;
                n_hold_count     = '0;
            end
        end else if (r_tracking) begin
            if (pin_low) begin
                n_hold_count = count_inc;
                if (count_inc >= i_click_limit) begin
                    n_press_flags = r_press_flags | button_bit;
                end
                if (count_inc >= i_timeout_limit) begin
                    n_press_flags = n_press_flags & ~button_bit;
                    n_hold_count  = '0;
                    n_tracking    = 1'b0;
                end
            end else begin
                // Release: a zero count is a bounce, a short count a click,
                // anything longer ends the long press.
                if (r_hold_count != '0) begin
                    if (r_hold_count < i_click_limit) begin
                        click = 1'b1;
                    end else begin
                        n_press_flags = r_press_flags & ~button_bit;
                    end
                end
                n_hold_count = '0;
                n_tracking   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking       <= 1'b0;
            r_tracked_button <= '0;
            r_hold_count     <= '0;
            r_press_flags    <= '0;
        end else if (i_step) begin
            r_tracking       <= n_tracking;
            r_tracked_button <= n_tracked_button;
            r_hold_count     <= n_hold_count;
            r_press_flags    <= n_press_flags;
        end
    end

    assign o_click_valid  = click;
    assign o_click_button = click ? r_tracked_button : '0;
    assign o_press_mask   = n_press_flags;
    assign o_busy_res     = n_tracking;

endmodule : bcpc_track

`default_nettype wire

// ===== sv/button_click_press_classifier.sv =====
// ============================================================================
// button_click_press_classifier - click / long-press detector for buttons
// Classifies pushes of active-low buttons into clicks and long presses.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per transaction:
//   either a falling edge on one button (mode 0, i_button_index) or a
//   debounce tick with all sampled pin levels (mode 1, i_pin_levels).
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   input transaction, in order: click event, press mask and busy flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the click limit
//   (index 0) and the timeout limit (index 1); it is always ready and should
//   only be used while no items are in flight.
//   Path: an accepted item waits in the input register, and its result is
//   written to the result register. Throughput is one item per cycle while
//   the receiver does not stall; it is set by the combinational update of
//   the tracking state between the input register and the result register.
//   When the receiver stalls, the result register holds its transaction and
//   the input register still takes one more item; after that o_in_ready drops
//   until the result is taken.
//   Synchronous active-low reset clears the tracking state, press flags and
//   both pipeline valid flags, and restores the default limits (8 and 10000).
// ============================================================================
`default_nettype none

module button_click_press_classifier
    import bcpc_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int unsigned BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_mode,
    input  wire logic [BTN_W-1:0]       i_button_index,
    input  wire logic [NUM_BUTTONS-1:0] i_pin_levels,
    // Output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_click_valid,
    output logic [BTN_W-1:0]            o_click_button,
    output logic [NUM_BUTTONS-1:0]      o_press_mask,
    output logic                        o_busy_res,
    // Configuration channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CNT_W-1:0]       i_cfg_data
);

    // Input register.
    logic                   r_in_valid;
    logic                   r_mode;
    logic [BTN_W-1:0]       r_button_index;
    logic [NUM_BUTTONS-1:0] r_pin_levels;

    // Result register.
    logic                   r_out_valid;
    logic                   r_click_valid;
    logic [BTN_W-1:0]       r_click_button;
    logic [NUM_BUTTONS-1:0] r_press_mask;
    logic                   r_busy_res;

    logic                   in_take;
    logic                   step;

    logic [CNT_W-1:0]       click_limit;
    logic [CNT_W-1:0]       timeout_limit;

    logic                   res_click_valid;
    logic [BTN_W-1:0]       res_click_button;
    logic [NUM_BUTTONS-1:0] res_press_mask;
    logic                   res_busy_res;

    // The item in the input register is processed when the result register
    // is empty or being drained in this same cycle.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_take    = i_in_valid && o_in_ready;

    bcpc_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_click_limit   (click_limit),
        .o_timeout_limit (timeout_limit)
    );

    bcpc_track #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .BTN_W       (BTN_W)
    ) u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_mode          (r_mode),
        .i_button_index  (r_button_index),
        .i_pin_levels    (r_pin_levels),
        .i_click_limit   (click_limit),
        .i_timeout_limit (timeout_limit),
        .o_click_valid   (res_click_valid),
        .o_click_button  (res_click_button),
        .o_press_mask    (res_press_mask),
        .o_busy_res      (res_busy_res)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode         <= i_mode;
            r_button_index <= i_button_index;
            r_pin_levels   <= i_pin_levels;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_click_valid  <= res_click_valid;
            r_click_button <= res_click_button;
            r_press_mask   <= res_press_mask;
            r_busy_res     <= res_busy_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_click_valid  = r_click_valid;
    assign o_click_button = r_click_button;
    assign o_press_mask   = r_press_mask;
    assign o_busy_res     = r_busy_res;

endmodule : button_click_press_classifier

`default_nettype wire

// ===== dv/tb_button_click_press_classifier.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_button_click_press_classifier - self-checking bench for the classifier
// Sends edge and debounce-tick items through the valid/ready input channel,
// predicts every result from a behavioral copy of the tracking state, and
// compares each result field by field while both channels idle at random.
// ============================================================================

module tb_button_click_press_classifier;
    import bcpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned MAX_REPORTS  = 40;
    localparam int unsigned MAX_HOLD     = 64;

    // One input item as the sender presents it.
    typedef struct packed {
        t_mode      mode;
        logic [1:0] button;
        logic [3:0] pins;
    } btn_item_t;

    // One result as the block returns it.
    typedef struct packed {
        logic       click;
        logic [1:0] click_btn;
        logic [3:0] press;
        logic       busy;
    } btn_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 i_in_valid     = 1'b0;
    logic                 i_mode         = 1'b0;
    logic [1:0]           i_button_index = '0;
    logic [3:0]           i_pin_levels   = '1;
    logic                 i_out_ready    = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CNT_W-1:0]     i_cfg_data     = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_click_valid;
    logic [1:0] o_click_button;
    logic [3:0] o_press_mask;
    logic       o_busy_res;
    logic       o_cfg_ready;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    button_click_press_classifier u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_button_index (i_button_index),
        .i_pin_levels   (i_pin_levels),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_click_valid  (o_click_valid),
        .o_click_button (o_click_button),
        .o_press_mask   (o_press_mask),
        .o_busy_res     (o_busy_res),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predicted state of the classifier and its two limit registers. The
    // limits start at their reset values and follow every accepted write.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] lim_click   = CLICK_LIMIT_RST;
    logic [CNT_W-1:0] lim_timeout = TIMEOUT_LIMIT_RST;
    logic             trk_active  = 1'b0;
    logic [1:0]       trk_button  = '0;
    logic [CNT_W-1:0] hold_ticks  = '0;
    logic [3:0]       long_flags  = '0;

    btn_item_t   pending_items[$];     // items waiting for the driver
    btn_result_t expected_results[$];  // predictions waiting for the block

    int unsigned cycle_count   = 0;
    int unsigned planned_items = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned clicks_seen   = 0;
    int unsigned press_seen    = 0;
    int unsigned timeouts_hit  = 0;
    int unsigned cfg_settings  = 0;
    int unsigned error_count   = 0;

    // Advances the predicted state by one accepted item and returns the
    // result the block has to produce for it.
    function automatic btn_result_t classify_item(btn_item_t it);
        btn_result_t res;
        logic [3:0]  btn_bit;
        res = '0;
        if (it.mode == MODE_EDGE) begin
            // An edge only matters while idle; it locks onto that button.
            if (!trk_active) begin
                trk_active = 1'b1;
                trk_button = it.button;
                hold_ticks = '0;
            end
        end else if (trk_active) begin
            btn_bit = 4'b0001 << trk_button;
            if (!it.pins[trk_button]) begin
                // Still held: count with saturation, then test both limits.
                if (hold_ticks != CNT_MAX) begin
                    hold_ticks = hold_ticks + CNT_W'(1);
                end
                if (hold_ticks >= lim_click) begin
                    long_flags = long_flags | btn_bit;
                end
                if (hold_ticks >= lim_timeout) begin
                    long_flags = long_flags & ~btn_bit;
                    trk_active = 1'b0;
                    hold_ticks = '0;
                    timeouts_hit++;
                end
            end else begin
                // Released: a zero count is a bounce, a short count is a
                // click, anything longer ends the long press.
                if (hold_ticks != '0 && hold_ticks < lim_click) begin
                    res.click     = 1'b1;
                    res.click_btn = trk_button;
                end else if (hold_ticks != '0) begin
                    long_flags = long_flags & ~btn_bit;
                end
                trk_active = 1'b0;
                hold_ticks = '0;
            end
        end
        res.press = long_flags;
        res.busy  = trk_active;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. Items go out in bursts of random length separated by
    // random gaps; now and then a long burst runs with no gap at all. The
    // prediction is made at the edge where the transaction is accepted.
    // ------------------------------------------------------------------------
    btn_item_t   in_flight;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(classify_item(in_flight));
                items_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_flight = pending_items.pop_front();
                    i_in_valid     <= 1'b1;
                    i_mode         <= in_flight.mode;
                    i_button_index <= in_flight.button;
                    i_pin_levels   <= in_flight.pins;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. The receiver picks its stall style at random from four:
    // always ready, coin flip, one cycle in five, and mostly ready.
    // ------------------------------------------------------------------------
    int unsigned stall_style = 0;
    btn_result_t exp_res;

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: result %0d field %s mismatch: expected %0d, actual %0d",
                         $time, results_seen, name, exp_val, act_val);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: extra result: expected none, actual %0d/%0d/%h/%0d",
                                 $time, o_click_valid, o_click_button, o_press_mask,
                                 o_busy_res);
                    end
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("click_valid", exp_res.click, o_click_valid);
                    check_field("click_button", exp_res.click_btn, o_click_button);
                    check_field("press_mask", exp_res.press, o_press_mask);
                    check_field("busy_res", exp_res.busy, o_busy_res);
                    if (exp_res.click) begin
                        clicks_seen++;
                    end
                    if (exp_res.press != '0) begin
                        press_seen++;
                    end
                end
                results_seen++;
            end
            if (cycle_count % 97 == 0) begin
                stall_style = $urandom_range(0, 3);
            end
            case (stall_style)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_ready <= (cycle_count % 5 == 0);
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_item(t_mode m, logic [1:0] b, logic [3:0] p);
        btn_item_t it;
        it.mode   = m;
        it.button = b;
        it.pins   = p;
        pending_items.push_back(it);
        planned_items++;
    endtask

    // A fully random item; most of these are ignored ticks or edges.
    task automatic push_noise();
        btn_item_t it;
        it.mode   = t_mode'($urandom_range(0, 1));
        it.button = 2'($urandom_range(0, 3));
        it.pins   = 4'($urandom_range(0, 15));
        pending_items.push_back(it);
        planned_items++;
    endtask

    // A tick with the given button held low or released, other pins random.
    task automatic push_tick(logic [1:0] b, logic level);
        logic [3:0] p;
        p    = 4'($urandom_range(0, 15));
        p[b] = level;
        push_item(MODE_TICK, b, p);
    endtask

    // One push of a random button: an edge, a hold length aimed at the
    // bounce, click, long press or timeout region, and usually a release.
    task automatic add_press_sequence();
        logic [1:0]  b;
        int unsigned hold;
        int unsigned lo;
        int unsigned hi;
        b = 2'($urandom_range(0, 3));
        push_item(MODE_EDGE, b, 4'($urandom_range(0, 15)));
        case ($urandom_range(0, 9))
            0: begin
                lo = 0;
                hi = 0;
            end
            1, 2, 3: begin
                lo = 1;
                hi = (lim_click > 1) ? lim_click - 1 : 1;
            end
            4, 5: begin
                lo = lim_click;
                hi = lim_click + 3;
            end
            6, 7: begin
                lo = (lim_timeout > 0) ? lim_timeout - 1 : 0;
                hi = lim_timeout + 1;
            end
            default: begin
                lo = 0;
                hi = 40;
            end
        endcase
        if (lo > MAX_HOLD) begin
            lo = MAX_HOLD;
        end
        if (hi > MAX_HOLD) begin
            hi = MAX_HOLD;
        end
        hold = $urandom_range(lo, hi);
        for (int unsigned i = 0; i < hold; i++) begin
            // Edges that arrive while a button is held must be ignored.
            if ($urandom_range(0, 7) == 0) begin
                push_item(MODE_EDGE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end
            push_tick(b, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) begin
            push_tick(b, 1'b1);
        end
    endtask

    // Random sequences with some noise mixed in, until the goal is met.
    task automatic add_random_phase(int unsigned count);
        int unsigned goal;
        goal = planned_items + count;
        while (planned_items < goal) begin
            if ($urandom_range(0, 6) == 0) begin
                push_noise();
            end else begin
                add_press_sequence();
            end
        end
    endtask

    // Holds the sender until every item has been answered, then lets the
    // pipeline settle so that a stray result would still be caught.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write, only issued while nothing is in flight.
    task automatic write_reg(t_cfg_reg idx, logic [CNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CLICK_LIMIT) begin
            lim_click = value;
        end else begin
            lim_timeout = value;
        end
    endtask

    task automatic set_limits(logic [CNT_W-1:0] click_val, logic [CNT_W-1:0] timeout_val);
        write_reg(CFG_CLICK_LIMIT, click_val);
        write_reg(CFG_TIMEOUT_LIMIT, timeout_val);
        cfg_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    int unsigned random_goal;
    int unsigned phase_len;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limits (click 8, timeout 10000).
        push_item(MODE_TICK, 2'd0, 4'h0);     // tick while idle changes nothing
        push_item(MODE_EDGE, 2'd3, 4'h0);     // lock onto button 3
        push_item(MODE_EDGE, 2'd1, 4'hF);     // edge while tracking is ignored
        push_item(MODE_TICK, 2'd0, 4'h8);     // button 3 up at count zero: bounce
        push_item(MODE_EDGE, 2'd0, 4'h0);
        for (int i = 0; i < 3; i++) begin
            push_item(MODE_TICK, 2'd0, 4'hE);
        end
        push_item(MODE_TICK, 2'd0, 4'hF);     // short hold: click on button 0
        push_item(MODE_EDGE, 2'd2, 4'h0);
        for (int i = 0; i < 8; i++) begin
            push_item(MODE_TICK, 2'd2, 4'hB); // eighth tick raises the press flag
        end
        push_item(MODE_TICK, 2'd2, 4'h4);     // release ends the long press
        push_item(MODE_EDGE, 2'd1, 4'hF);
        push_item(MODE_TICK, 2'd1, 4'hD);
        push_item(MODE_TICK, 2'd1, 4'h2);     // one-tick click on button 1
        wait_drained();
        random_goal = planned_items + RANDOM_ITEMS;
        add_random_phase(100);
        wait_drained();

        // Limits of one: every low tick is a press and a timeout.
        set_limits(14'd1, 14'd1);
        add_random_phase(90);
        wait_drained();

        // Zero limits: timeout on the first low tick, then a press on every
        // low tick with a short timeout.
        set_limits(14'd0, 14'd0);
        push_item(MODE_TICK, 2'd0, 4'hF);
        push_item(MODE_EDGE, 2'd3, 4'h0);
        push_item(MODE_TICK, 2'd0, 4'h7);
        add_random_phase(40);
        wait_drained();
        write_reg(CFG_TIMEOUT_LIMIT, 14'd4);
        cfg_settings++;
        add_random_phase(60);
        wait_drained();

        // Highest limits: every release after a nonzero hold is a click. The last hold is left
        // open across a write that lowers the timeout below its count, so
        // the next low tick times out.
        set_limits(CNT_MAX, CNT_MAX);
        add_random_phase(90);
        push_item(MODE_TICK, 2'd0, 4'hF);
        push_item(MODE_EDGE, 2'd2, 4'h0);
        for (int i = 0; i < 20; i++) begin
            push_tick(2'd2, 1'b0);
        end
        wait_drained();
        set_limits(14'd3, 14'd5);
        push_tick(2'd2, 1'b0);
        wait_drained();

        // Random small limit pairs, timeout sometimes below the click limit.
        while (planned_items < random_goal) begin
            set_limits(CNT_W'($urandom_range(1, 10)), CNT_W'($urandom_range(1, 30)));
            phase_len = $urandom_range(100, 200);
            if (phase_len > random_goal - planned_items) begin
                phase_len = random_goal - planned_items;
            end
            add_random_phase(phase_len);
            wait_drained();
        end

        $display("Covered %0d items and %0d results over %0d limit settings.",
                 items_sent, results_seen, cfg_settings);
        $display("Saw %0d clicks, %0d results with a press held and %0d timeouts.",
                 clicks_seen, press_seen, timeouts_hit);
        if (error_count == 0) begin
            $display("button_click_press_classifier verification clean");
        end else begin
            $display("button_click_press_classifier verification failed");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t: run exceeded %0d cycles with %0d results outstanding",
                 $time, CYCLE_LIMIT, expected_results.size());
        $display("button_click_press_classifier verification failed");
        $finish;
    end

endmodule
